// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, held off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication check on clk, held off while arst_n is low.
`define ASSERT_IMPL(label, pre, post, msg) \
	`ASSERT_CLK(label, (pre) |-> (post), msg)

`endif

// ===== hw/rtl/ceacc_pkg.sv =====
package ceacc_pkg;

	localparam int NUM_CHANNELS = 32;
	localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CHAN_W       = 5;
	localparam int CODE_W       = 32;
	localparam int VAL_W        = 24;
	localparam int SUM_W        = 32;
	localparam int TIME_W       = 32;

	localparam logic REQ_POINT = 1'b0;
	localparam logic REQ_EOE   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PT_UPD,
		ST_SC_RD,
		ST_SC_EMIT
	} state_t;

	typedef struct packed {
		logic [SUM_W-1:0] energy;
		logic [SUM_W-1:0] fast;
		logic [SUM_W-1:0] slow;
	} sums_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {{(SUM_W + 1 - VAL_W){1'b0}}, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/channel_energy_accumulator.sv =====
// Point beat: stays in ST_IDLE when it changes no sums; otherwise read, then add and write back (ST_PT_UPD).
// End-of-event beat: accepted in ST_IDLE; the scan then visits each channel in ST_SC_RD up to and
// including the highest filled channel, and emits a hit in ST_SC_EMIT for each filled one; the hit
// output register stalls the scan while a hit waits to be taken.
// With channel 0 filled, the first hit goes through ST_SC_RD and ST_SC_EMIT into the output register.
// Reset (arst_n low) clears all sums through per-channel valid bits, the event time and the output
// valid flag; the end of each event clears the sums and the event time the same way, not the output.
`include "assert_macros.svh"

module channel_energy_accumulator import ceacc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [CHAN_W-1:0]   channel,
	input  logic [CODE_W-1:0]   particle_code,
	input  logic [VAL_W-1:0]    energy_loss,
	input  logic [VAL_W-1:0]    fast_light,
	input  logic [VAL_W-1:0]    slow_light,
	input  logic [TIME_W-1:0]   point_time,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CHAN_W-1:0]   hit_channel,
	output logic [SUM_W-1:0]    energy_sum,
	output logic [SUM_W-1:0]    fast_sum,
	output logic [SUM_W-1:0]    slow_sum,
	output logic [TIME_W-1:0]   hit_time,
	output logic                last_hit
);

	state_t state_q, state_d;

	logic [NUM_CHANNELS-1:0] valid_q;
	logic [CH_IDX_W-1:0]     idx_q;
	logic [TIME_W-1:0]       event_time_q;

	sums_t                   mem [NUM_CHANNELS];
	sums_t                   rd_data_s1;
	logic [CH_IDX_W-1:0]     rd_addr;

	logic [CH_IDX_W-1:0]     pt_addr_s1;
	logic [VAL_W-1:0]        pt_de_s1;
	logic [VAL_W-1:0]        pt_fa_s1;
	logic [VAL_W-1:0]        pt_sl_s1;

	logic                    out_valid_q;
	logic [CHAN_W-1:0]       hit_channel_q;
	sums_t                   hit_sums_q;
	logic [TIME_W-1:0]       hit_time_q;
	logic                    last_hit_q;

	logic                    in_acc;
	logic                    pt_take;
	logic                    ch_ok;
	logic                    pt_do;
	logic [NUM_CHANNELS-1:0] rest;
	logic                    rest_none;
	logic                    is_last;
	logic                    out_free;
	logic                    mem_we;
	logic                    out_load;
	logic                    idx_inc;
	logic                    scan_done;
	sums_t                   old_sums;
	sums_t                   new_sums;

	assign in_acc   = in_valid && in_ready;
	assign ch_ok    = (32'(channel) < 32'(NUM_CHANNELS));
	assign pt_take  = in_acc && (req_type == REQ_POINT) && (particle_code != '0);
	assign pt_do    = pt_take && (energy_loss != '0) && ch_ok;

	// Filled channels at or above the scan index.
	assign rest      = valid_q >> idx_q;
	assign rest_none = (rest == '0);
	assign is_last   = ((rest >> 1) == '0);
	assign out_free  = !out_valid_q || out_ready;

	assign old_sums        = valid_q[pt_addr_s1] ? rd_data_s1 : '0;
	assign new_sums.energy = sat_add(old_sums.energy, pt_de_s1);
	assign new_sums.fast   = sat_add(old_sums.fast, pt_fa_s1);
	assign new_sums.slow   = sat_add(old_sums.slow, pt_sl_s1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (req_type == REQ_EOE)
						state_d = ST_SC_RD;
					else if (pt_do)
						state_d = ST_PT_UPD;
				end
			end
			ST_PT_UPD: state_d = ST_IDLE;
			ST_SC_RD: begin
				if (rest_none)
					state_d = ST_IDLE;
				else if (valid_q[idx_q])
					state_d = ST_SC_EMIT;
			end
			ST_SC_EMIT: begin
				if (out_free)
					state_d = is_last ? ST_IDLE : ST_SC_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		rd_addr   = idx_q;
		mem_we    = 1'b0;
		out_load  = 1'b0;
		idx_inc   = 1'b0;
		scan_done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = CH_IDX_W'(channel);
			end
			ST_PT_UPD: mem_we = 1'b1;
			ST_SC_RD: begin
				scan_done = rest_none;
				idx_inc   = !rest_none && !valid_q[idx_q];
			end
			ST_SC_EMIT: begin
				out_load  = out_free;
				idx_inc   = out_free && !is_last;
				scan_done = out_free && is_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			idx_q        <= '0;
			event_time_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// drop every sum and the event time once the scan is through
			if (scan_done) begin
				valid_q      <= '0;
				event_time_q <= '0;
				idx_q        <= '0;
			end else begin
				if (mem_we)
					valid_q[pt_addr_s1] <= 1'b1;
				if (pt_take)
					event_time_q <= point_time;
				if (idx_inc)
					idx_q <= idx_q + CH_IDX_W'(1);
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Sum memory: one read port with registered data, one write port.
	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[rd_addr];
		if (mem_we)
			mem[pt_addr_s1] <= new_sums;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pt_addr_s1 <= CH_IDX_W'(channel);
			pt_de_s1   <= energy_loss;
			pt_fa_s1   <= fast_light;
			pt_sl_s1   <= slow_light;
		end
		if (out_load) begin
			hit_channel_q <= CHAN_W'(idx_q);
			hit_sums_q    <= rd_data_s1;
			hit_time_q    <= event_time_q;
			last_hit_q    <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit_channel = hit_channel_q;
	assign energy_sum  = hit_sums_q.energy;
	assign fast_sum    = hit_sums_q.fast;
	assign slow_sum    = hit_sums_q.slow;
	assign hit_time    = hit_time_q;
	assign last_hit    = last_hit_q;

	`ASSERT_IMPL(a_upd_after_idle, state_q == ST_PT_UPD, $past(state_q) == ST_IDLE, "update without accepted point")
	`ASSERT_IMPL(a_emit_filled, state_q == ST_SC_EMIT, valid_q[idx_q], "emit on empty channel")
	`ASSERT_CLK(a_done_clears, scan_done |=> (valid_q == '0) && (event_time_q == '0), "scan end did not clear")
	`ASSERT_IMPL(a_load_free, out_load, out_free, "hit loaded over a waiting hit")

endmodule
